@@ sv/hsd_pkg.sv @@
// Shared types, constants and the codeword table function of the Hamming(7,4) soft decoder.
`timescale 1ns / 1ps

package hsd_pkg;

    // Code geometry.
    localparam int NUM_POS  = 7;
    localparam int NUM_CAND = 16;
    localparam int HARD_W   = 7;
    localparam int IDX_W    = 4;
    localparam int BITS_W   = 4;

    // Fixed-point score format, 1.0 is 2**Q_SHIFT.
    localparam int REL_W   = 16;
    localparam int SCORE_W = 17;
    localparam int Q_SHIFT = 16;
    localparam int PROD_W  = 2 * SCORE_W;
    localparam logic [SCORE_W-1:0] Q_ONE = SCORE_W'(1) << Q_SHIFT;

    // Stream widths, padded to whole bytes.
    localparam int S_DATA_RAW = HARD_W + NUM_POS * REL_W;
    localparam int S_DATA_W   = ((S_DATA_RAW + 7) / 8) * 8;
    localparam int M_DATA_RAW = BITS_W + SCORE_W;
    localparam int M_DATA_W   = ((M_DATA_RAW + 7) / 8) * 8;

    // Comparison tree depth and total pipeline depth.
    localparam int NUM_LVL    = $clog2(NUM_CAND);
    localparam int NUM_STAGES = NUM_POS + NUM_LVL;
    localparam int CNT_W      = $clog2(NUM_STAGES + 1);

    typedef logic [REL_W-1:0]   rel_t;
    typedef logic [SCORE_W-1:0] score_t;

    // Request as it travels down the chain of position cells.
    typedef struct packed {
        logic [HARD_W-1:0]           hard;
        rel_t   [NUM_POS-1:0]        rel;
        score_t [NUM_CAND-1:0]       score;
    } item_t;

    // One candidate in the comparison tree.
    typedef struct packed {
        score_t             score;
        logic [IDX_W-1:0]   idx;
    } cand_t;

    // Codeword of candidate idx = d0*8 + d1*4 + d2*2 + d3, bit i is position i.
    function automatic logic [HARD_W-1:0] cand_codeword(input logic [IDX_W-1:0] idx);
        logic d0;
        logic d1;
        logic d2;
        logic d3;
        d0 = idx[3];
        d1 = idx[2];
        d2 = idx[1];
        d3 = idx[0];
        return {d0 ^ d1 ^ d3, d1 ^ d2 ^ d3, d0 ^ d1 ^ d2, d3, d2, d1, d0};
    endfunction

endpackage

@@ sv/hsd_pos_cell.sv @@
// One position cell: scales all sixteen candidate scores by the factor of its code position.
`timescale 1ns / 1ps

module hsd_pos_cell #(
    parameter int POS = 0
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  hsd_pkg::item_t in_item,
    output logic          out_valid,
    input  logic          out_ready,
    output hsd_pkg::item_t out_item
);
    import hsd_pkg::*;

    logic   out_valid_reg;
    logic   out_valid_next;
    item_t  item_reg;
    item_t  item_next;
    score_t f_agree;
    score_t f_differ;

    // The stage may load when it is empty or its contents move on.
    assign in_ready = !out_valid_reg || out_ready;

    // Factors for an agreeing and a disagreeing candidate bit.
    assign f_agree  = {1'b0, in_item.rel[POS]};
    assign f_differ = Q_ONE - {1'b0, in_item.rel[POS]};

    // Multiply every candidate score by its factor and drop the fraction.
    always_comb
    begin
        logic [HARD_W-1:0] cw;
        score_t            f;
        logic [PROD_W-1:0] prod;
        item_next = in_item;
        for (int c = 0; c < NUM_CAND; c++)
        begin
            cw   = cand_codeword(IDX_W'(c));
            f    = (cw[POS] == in_item.hard[POS]) ? f_agree : f_differ;
            prod = PROD_W'(in_item.score[c]) * PROD_W'(f);
            item_next.score[c] = prod[Q_SHIFT+SCORE_W-1:Q_SHIFT];
        end
    end

    assign out_valid_next = in_ready ? in_valid : out_valid_reg;

    // Stage valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Stage payload.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = item_reg;

endmodule

@@ sv/hsd_cmp_cell.sv @@
// One comparison level: halves the candidate list, keeping the larger score of each pair.
`timescale 1ns / 1ps

module hsd_cmp_cell #(
    parameter int N_IN = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  hsd_pkg::cand_t [N_IN-1:0]     in_cand,
    output logic                          out_valid,
    input  logic                          out_ready,
    output hsd_pkg::cand_t [N_IN/2-1:0]   out_cand
);
    import hsd_pkg::*;

    localparam int N_OUT = N_IN / 2;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    cand_t [N_OUT-1:0]    cand_reg;
    cand_t [N_OUT-1:0]    cand_next;

    assign in_ready = !out_valid_reg || out_ready;

    // The upper candidate wins only with a strictly larger score, so ties keep the lower index.
    always_comb
    begin
        for (int k = 0; k < N_OUT; k++)
        begin
            if (in_cand[2*k+1].score > in_cand[2*k].score)
            begin
                cand_next[k] = in_cand[2*k+1];
            end
            else
            begin
                cand_next[k] = in_cand[2*k];
            end
        end
    end

    assign out_valid_next = in_ready ? in_valid : out_valid_reg;

    // Stage valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Stage payload.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cand_reg <= cand_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_cand  = cand_reg;

endmodule

@@ sv/hamming74_soft_ml_decoder_unit.sv @@
// Top level of the Hamming(7,4) soft-decision maximum-likelihood decoder.
//
// The decoder takes one received word per clock cycle and delivers one result per cycle; a
// request passes through registered stages on its way to the result: seven position cells, one per code position,
// each scale all sixteen candidate scores by a 17 x 17 bit product, and four registered compare
// levels then reduce the sixteen candidates to the winner, with ties going to the lowest
// candidate index. Every stage holds its request under back-pressure and loads again as soon
// as its contents move on, so the full rate is kept whenever the result side takes every cycle.
`timescale 1ns / 1ps

module hamming74_soft_ml_decoder_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // Fields from bit 0 up: hard_bits[6:0], rel_0 .. rel_6 (16 bits each), zero pad.
    input  logic [hsd_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // Fields from bit 0 up: decoded_bits[3:0], best_score[16:0], zero pad.
    output logic [hsd_pkg::M_DATA_W-1:0]  m_tdata
);
    import hsd_pkg::*;

    logic  [NUM_STAGES:0]           stage_valid;
    logic  [NUM_STAGES:0]           stage_ready;
    item_t                          pos_item [0:NUM_POS];
    cand_t [NUM_CAND-1:0]           lvl_cand [0:NUM_LVL];
    cand_t                          winner;
    logic  [CNT_W-1:0]              inflight_reg;
    logic  [CNT_W-1:0]              inflight_next;

    // Unpack the incoming request; every score starts at 1.0.
    always_comb
    begin
        pos_item[0].hard = s_tdata[HARD_W-1:0];
        for (int p = 0; p < NUM_POS; p++)
        begin
            pos_item[0].rel[p] = s_tdata[HARD_W + p*REL_W +: REL_W];
        end
        for (int c = 0; c < NUM_CAND; c++)
        begin
            pos_item[0].score[c] = Q_ONE;
        end
    end

    assign stage_valid[0]          = s_tvalid;
    assign s_tready                = stage_ready[0];
    assign stage_ready[NUM_STAGES] = m_tready;

    // Chain of position cells.
    for (genvar p = 0; p < NUM_POS; p++)
    begin : g_pos
        hsd_pos_cell #(
            .POS (p)
        ) u_pos (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stage_valid[p]),
            .in_ready  (stage_ready[p]),
            .in_item   (pos_item[p]),
            .out_valid (stage_valid[p+1]),
            .out_ready (stage_ready[p+1]),
            .out_item  (pos_item[p+1])
        );
    end

    // Tag each final score with its candidate index.
    always_comb
    begin
        for (int c = 0; c < NUM_CAND; c++)
        begin
            lvl_cand[0][c].score = pos_item[NUM_POS].score[c];
            lvl_cand[0][c].idx   = IDX_W'(c);
        end
    end

    // Registered comparison tree.
    for (genvar l = 0; l < NUM_LVL; l++)
    begin : g_lvl
        localparam int N_IN = NUM_CAND >> l;

        hsd_cmp_cell #(
            .N_IN (N_IN)
        ) u_cmp (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stage_valid[NUM_POS+l]),
            .in_ready  (stage_ready[NUM_POS+l]),
            .in_cand   (lvl_cand[l][N_IN-1:0]),
            .out_valid (stage_valid[NUM_POS+l+1]),
            .out_ready (stage_ready[NUM_POS+l+1]),
            .out_cand  (lvl_cand[l+1][N_IN/2-1:0])
        );

        assign lvl_cand[l+1][NUM_CAND-1:N_IN/2] = '0;
    end

    // Pack the result; the candidate index carries d0 in its top bit.
    assign winner   = lvl_cand[NUM_LVL][0];
    assign m_tvalid = stage_valid[NUM_STAGES];
    assign m_tdata  = {(M_DATA_W-M_DATA_RAW)'(0), winner.score,
                       winner.idx[0], winner.idx[1], winner.idx[2], winner.idx[3]};

    // Count of requests inside the pipeline, for checking the stage flags.
    always_comb
    begin
        inflight_next = inflight_reg;
        if ((s_tvalid && s_tready) && !(m_tvalid && m_tready))
        begin
            inflight_next = inflight_reg + CNT_W'(1);
        end
        else if (!(s_tvalid && s_tready) && (m_tvalid && m_tready))
        begin
            inflight_next = inflight_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    // A taken result lets every stage move, so the input side must be open.
    a_ready_chain : assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("input not ready although the result side is taking");

    // The winning score never exceeds 1.0.
    a_score_range : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[BITS_W+SCORE_W-1:BITS_W] <= Q_ONE))
        else $error("best score above 1.0");

    // Requests are neither lost nor duplicated between the stages.
    a_inflight : assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg == CNT_W'($countones(stage_valid[NUM_STAGES:1])))
        else $error("stage valid flags disagree with the request count");

    // The pipeline never holds more requests than it has stages.
    a_inflight_max : assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= CNT_W'(NUM_STAGES))
        else $error("request count above pipeline depth");

endmodule
